>>> hdl/smh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the streaming sha-1 hash unit
// used by smh_ctrl, smh_datapath, sha1_message_hash_unit and tb_top

package smh_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int WNUM_W      = 3;
  localparam int FILL_W      = 6;
  localparam int CNT_W       = 61;
  localparam int RND_W       = 7;

  localparam logic [FILL_W-1:0] FILL_LAST    = 6'd63;
  localparam logic [FILL_W-1:0] FILL_PRE_LEN = 6'd55;
  localparam logic [RND_W-1:0]  RND_LAST     = 7'd79;
  localparam logic [RND_W-1:0]  RND_GRP1     = 7'd20;
  localparam logic [RND_W-1:0]  RND_GRP2     = 7'd40;
  localparam logic [RND_W-1:0]  RND_GRP3     = 7'd60;
  localparam logic [WNUM_W-1:0] WORD_LAST    = 3'd4;
  localparam logic [7:0]        PAD_MARK     = 8'h80;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_COMP     = 7'b0000010,
    ST_FOLD     = 7'b0000100,
    ST_PAD_MARK = 7'b0001000,
    ST_PAD_ZERO = 7'b0010000,
    ST_PAD_LEN  = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } ins_sel_t;

  typedef enum logic [1:0] {
    RG_CH,
    RG_PAR1,
    RG_MAJ,
    RG_PAR2
  } rgrp_t;

  typedef struct packed {
    logic     ins;
    ins_sel_t sel;
    logic     cnt_inc;
    logic     rnd;
    rgrp_t    rgrp;
    logic     fold;
    logic     out_step;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_pre_len;
    logic word_last;
  } status_t;

endpackage

>>> hdl/sha1_message_hash_unit.sv
`timescale 1ns / 1ps
// Streaming SHA-1 hash unit. Message bytes enter one per request on the input stream
// (in_tuser marks a real byte, in_tlast ends the message and may come without a byte);
// the 160-bit digest leaves as five big-endian words, word 0 first, the fifth one with
// out_tlast. The byte that completes a 64-byte block is followed by the 80 rounds
// through the single round unit, one per cycle, and a fold of the result into the
// chaining words, during which in_tready is low. The final request then inserts
// padding and the length one byte per cycle outside the compressions (9 to 72 bytes,
// one or two more block compressions) and presents the five digest words, one
// per cycle while out_tready is high. The byte count saturates at 2^61-1. No new
// message byte is taken until the last digest word has gone.
// depends on smh_pkg, smh_ctrl, smh_datapath

module sha1_message_hash_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [smh_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                                in_tuser,   // [0] byte_valid
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [smh_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] digest_word, [34:32] word_number, [39:35] zero
  output logic                                out_tlast
);

  smh_pkg::cmd_t                   cmd;
  smh_pkg::status_t                sts;
  logic [31:0]                     out_word;
  logic [smh_pkg::WNUM_W-1:0]      out_wnum;

  smh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  smh_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_byte  (in_tdata),
    .out_word (out_word),
    .out_wnum (out_wnum)
  );

  assign out_tdata = {5'b00000, out_wnum, out_word};
  assign out_tlast = sts.word_last;

endmodule

>>> hdl/smh_ctrl.sv
`timescale 1ns / 1ps
// control state machine of the sha-1 hash unit: byte intake, padding, rounds, digest output
// depends on smh_pkg

module smh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_tuser,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  smh_pkg::status_t sts,
  output smh_pkg::cmd_t    cmd
);

  smh_pkg::state_t                state_r, state_nxt;
  smh_pkg::state_t                ret_r, ret_nxt;
  logic [smh_pkg::RND_W-1:0]      rnd_r, rnd_nxt;
  logic                           in_acc;

  assign in_tready  = (state_r == smh_pkg::ST_IDLE);
  assign out_tvalid = (state_r == smh_pkg::ST_EMIT);
  assign in_acc     = in_tvalid & in_tready;

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    rnd_nxt      = rnd_r;
    cmd          = '0;
    cmd.sel      = smh_pkg::SEL_IN;
    if (rnd_r < smh_pkg::RND_GRP1) begin
      cmd.rgrp = smh_pkg::RG_CH;
    end else if (rnd_r < smh_pkg::RND_GRP2) begin
      cmd.rgrp = smh_pkg::RG_PAR1;
    end else if (rnd_r < smh_pkg::RND_GRP3) begin
      cmd.rgrp = smh_pkg::RG_MAJ;
    end else begin
      cmd.rgrp = smh_pkg::RG_PAR2;
    end
    case (state_r)
      smh_pkg::ST_IDLE: begin
        cmd.ins     = in_acc & in_tuser;
        cmd.cnt_inc = in_acc & in_tuser;
        if (in_acc) begin
          if (in_tuser && sts.fill_last) begin
            state_nxt = smh_pkg::ST_COMP;
            ret_nxt   = in_tlast ? smh_pkg::ST_PAD_MARK : smh_pkg::ST_IDLE;
          end else if (in_tlast) begin
            state_nxt = smh_pkg::ST_PAD_MARK;
          end
        end
      end
      smh_pkg::ST_COMP: begin
        cmd.rnd = 1'b1;
        if (rnd_r == smh_pkg::RND_LAST) begin
          rnd_nxt   = '0;
          state_nxt = smh_pkg::ST_FOLD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      smh_pkg::ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ret_r;
      end
      smh_pkg::ST_PAD_MARK: begin
        cmd.ins = 1'b1;
        cmd.sel = smh_pkg::SEL_MARK;
        if (sts.fill_last) begin
          state_nxt = smh_pkg::ST_COMP;
          ret_nxt   = smh_pkg::ST_PAD_ZERO;
        end else if (sts.fill_pre_len) begin
          state_nxt = smh_pkg::ST_PAD_LEN;
        end else begin
          state_nxt = smh_pkg::ST_PAD_ZERO;
        end
      end
      smh_pkg::ST_PAD_ZERO: begin
        cmd.ins = 1'b1;
        cmd.sel = smh_pkg::SEL_ZERO;
        if (sts.fill_last) begin
          state_nxt = smh_pkg::ST_COMP;
          ret_nxt   = smh_pkg::ST_PAD_ZERO;
        end else if (sts.fill_pre_len) begin
          state_nxt = smh_pkg::ST_PAD_LEN;
        end
      end
      smh_pkg::ST_PAD_LEN: begin
        cmd.ins = 1'b1;
        cmd.sel = smh_pkg::SEL_LEN;
        if (sts.fill_last) begin
          state_nxt = smh_pkg::ST_COMP;
          ret_nxt   = smh_pkg::ST_EMIT;
        end
      end
      smh_pkg::ST_EMIT: begin
        cmd.out_step = out_tready;
        if (out_tready && sts.word_last) begin
          state_nxt = smh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smh_pkg::ST_IDLE;
      ret_r   <= smh_pkg::ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

endmodule

>>> hdl/smh_datapath.sv
`timescale 1ns / 1ps
// datapath of the sha-1 hash unit: block shift line, message schedule, round unit, chaining words
// depends on smh_pkg

module smh_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  smh_pkg::cmd_t                    cmd,
  output smh_pkg::status_t                 sts,
  input  logic [smh_pkg::IN_TDATA_W-1:0]   in_byte,
  output logic [31:0]                      out_word,
  output logic [smh_pkg::WNUM_W-1:0]       out_wnum
);

  logic [511:0]                  blk_r;
  logic [smh_pkg::FILL_W-1:0]    fill_r;
  logic [smh_pkg::CNT_W-1:0]     cnt_r;
  logic [smh_pkg::WNUM_W-1:0]    wnum_r;
  logic [31:0]                   h_r  [5];
  logic [31:0]                   wk_r [5];

  logic [7:0]  ins_byte;
  logic [63:0] len_bits;
  logic [2:0]  len_idx;
  logic [31:0] w0, w2, w8, w13, wx, wnew;
  logic [31:0] fn, kc, tmp;

  assign len_bits = {cnt_r, 3'b000};
  assign len_idx  = 3'd7 - fill_r[2:0];

  always_comb begin
    case (cmd.sel)
      smh_pkg::SEL_IN:   ins_byte = in_byte;
      smh_pkg::SEL_MARK: ins_byte = smh_pkg::PAD_MARK;
      smh_pkg::SEL_ZERO: ins_byte = 8'h00;
      smh_pkg::SEL_LEN:  ins_byte = len_bits[{len_idx, 3'b000} +: 8];
      default:           ins_byte = 8'h00;
    endcase
  end

  // schedule window, word 0 is the current round word
  assign w0   = blk_r[511:480];
  assign w2   = blk_r[447:416];
  assign w8   = blk_r[255:224];
  assign w13  = blk_r[95:64];
  assign wx   = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    case (cmd.rgrp)
      smh_pkg::RG_CH: begin
        fn = (wk_r[1] & wk_r[2]) | (~wk_r[1] & wk_r[3]);
        kc = smh_pkg::K_CH;
      end
      smh_pkg::RG_PAR1: begin
        fn = wk_r[1] ^ wk_r[2] ^ wk_r[3];
        kc = smh_pkg::K_PAR1;
      end
      smh_pkg::RG_MAJ: begin
        fn = (wk_r[1] & wk_r[2]) | (wk_r[1] & wk_r[3]) | (wk_r[2] & wk_r[3]);
        kc = smh_pkg::K_MAJ;
      end
      smh_pkg::RG_PAR2: begin
        fn = wk_r[1] ^ wk_r[2] ^ wk_r[3];
        kc = smh_pkg::K_PAR2;
      end
      default: begin
        fn = '0;
        kc = '0;
      end
    endcase
  end

  assign tmp = {wk_r[0][26:0], wk_r[0][31:27]} + fn + wk_r[4] + kc + w0;

  assign sts.fill_last    = (fill_r == smh_pkg::FILL_LAST);
  assign sts.fill_pre_len = (fill_r == smh_pkg::FILL_PRE_LEN);
  assign sts.word_last    = (wnum_r == smh_pkg::WORD_LAST);

  assign out_word = h_r[wnum_r];
  assign out_wnum = wnum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
      wnum_r <= '0;
      h_r    <= smh_pkg::H_INIT;
    end else begin
      if (cmd.ins) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.cnt_inc && !(&cnt_r)) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 5; i++) begin
          h_r[i] <= h_r[i] + wk_r[i];
        end
      end
      if (cmd.out_step) begin
        if (wnum_r == smh_pkg::WORD_LAST) begin
          wnum_r <= '0;
          cnt_r  <= '0;
          h_r    <= smh_pkg::H_INIT;
        end else begin
          wnum_r <= wnum_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      blk_r <= {blk_r[503:0], ins_byte};
    end else if (cmd.rnd) begin
      blk_r <= {blk_r[479:0], wnew};
    end
    if (cmd.ins && (fill_r == smh_pkg::FILL_LAST)) begin
      wk_r <= h_r;
    end else if (cmd.rnd) begin
      wk_r[0] <= tmp;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= {wk_r[1][1:0], wk_r[1][31:2]};
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3];
    end
  end

endmodule

>>> hdl/smh_checker.sv
`timescale 1ns / 1ps
// port-level checks of the sha-1 hash unit, bound to the top level
// depends on sha1_message_hash_unit

module smh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("digest word changed while stalled");

  // no intake while the digest is out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during digest output");

  // words follow in order
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[34:32] == $past(out_tdata[34:32]) + 3'd1))
    else $error("digest word out of sequence");

  // last word ends the digest and reopens intake
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("digest did not end after last word");

  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[34:32] == 3'd4)))
    else $error("last mark on wrong word");

endmodule

bind sha1_message_hash_unit smh_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for sha1_message_hash_unit: byte requests in, digest words out,
// checked against an sha-1 predictor kept in this file; depends on smh_pkg and the rtl

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } msg_req_t;

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  wnum;
    logic        fin;
  } digest_word_t;

  typedef enum {
    PH_STEADY,
    PH_SRC_GAPS,
    PH_SINK_STALL,
    PH_BOTH_GAPS,
    PH_BACKPRESSURE
  } phase_t;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RK_CH   = 32'h5A827999;
  localparam logic [31:0] RK_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] RK_PAR2 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int HOLD_LEN   = 300;
  localparam int PHASE_REQS = 10;
  localparam int EDGE_LEN [4] = '{55, 56, 63, 64};
  localparam phase_t RUN_PHASES [4] = '{PH_SRC_GAPS, PH_SINK_STALL, PH_BOTH_GAPS,
                                        PH_BACKPRESSURE};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [smh_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [smh_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  phase_t phase = PH_STEADY;
  msg_req_t pending_reqs [$];
  digest_word_t digest_fifo [$];
  msg_req_t drv_req;
  int hold_cycles = 0;
  int queued_reqs = 0;
  int err_cnt = 0;
  int accepted_reqs = 0;
  int msg_cnt = 0;
  int words_checked = 0;

  // predictor state
  logic [31:0] hash_h [5];
  logic [7:0]  blk_bytes [64];
  logic [60:0] byte_cnt;
  int          fill;

  sha1_message_hash_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void sha1_clear();
    for (int i = 0; i < 5; i++) hash_h[i] = SHA1_IV[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    byte_cnt = '0;
    fill = 0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    for (int r = 16; r < 80; r++) begin
      t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = RK_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = RK_PAR1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = RK_MAJ;
      end else begin
        f = b ^ c ^ d; k = RK_PAR2;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
  endfunction

  function automatic void sha1_absorb(input logic [7:0] v);
    blk_bytes[fill] = v;
    fill++;
    if (fill == 64) begin
      sha1_compress();
      fill = 0;
    end
  endfunction

  // takes one accepted request, queues the digest words it produces
  function automatic void sha1_predict(input msg_req_t req);
    logic [63:0] bit_len;
    digest_word_t dw;
    if (req.has_byte) begin
      sha1_absorb(req.data);
      if (byte_cnt != '1) byte_cnt++;
    end
    if (req.eom) begin
      bit_len = {byte_cnt, 3'b000};
      sha1_absorb(PAD_BYTE);
      while (fill != 56) sha1_absorb(8'h00);
      for (int i = 0; i < 8; i++) sha1_absorb(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        dw.digest = hash_h[i];
        dw.wnum = 3'(i);
        dw.fin = (i == 4);
        digest_fifo.push_back(dw);
      end
      sha1_clear();
    end
  endfunction

  task automatic push_req(input logic [7:0] data, input logic has_byte, input logic eom);
    msg_req_t req;
    req.data = data;
    req.has_byte = has_byte;
    req.eom = eom;
    pending_reqs.push_back(req);
    if (has_byte || eom) queued_reqs++;
  endtask

  // message of len bytes with random content and some ignored requests mixed in
  task automatic queue_message(input int len, input bit tail_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) push_req(8'($urandom_range(255)), 1'b0, 1'b0);
      push_req(8'($urandom_range(255)), 1'b1, tail_byte && (i == len - 1));
    end
    if (!tail_byte) push_req(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || digest_fifo.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() != 0 &&
          !((phase == PH_SRC_GAPS && $urandom_range(99) < 84) ||
            (phase == PH_BOTH_GAPS && $urandom_range(99) < 25))) begin
        drv_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= drv_req.data;
        in_tuser <= drv_req.has_byte;
        in_tlast <= drv_req.eom;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off at the start of the backpressure phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (phase == PH_BACKPRESSURE && hold_cycles < HOLD_LEN) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      case (phase)
        PH_SINK_STALL: out_tready <= ($urandom_range(99) >= 84);
        PH_BOTH_GAPS: out_tready <= ($urandom_range(99) >= 25);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_word_t want, got;
    msg_req_t seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.digest = out_tdata[31:0];
        got.wnum = out_tdata[34:32];
        got.fin = out_tlast;
        if (digest_fifo.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected digest word, expected none, got %h word %0d last %0b",
                   $time, got.digest, got.wnum, got.fin);
        end else begin
          want = digest_fifo.pop_front();
          words_checked++;
          if (got != want) begin
            err_cnt++;
            $display("%0t: expected %h word %0d last %0b, got %h word %0d last %0b",
                     $time, want.digest, want.wnum, want.fin, got.digest, got.wnum, got.fin);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        seen.data = in_tdata;
        seen.has_byte = in_tuser;
        seen.eom = in_tlast;
        accepted_reqs++;
        if (in_tlast) msg_cnt++;
        sha1_predict(seen);
      end
    end
  end

  initial begin
    int len;
    int start;
    int n_msg;
    int bnd_len;
    sha1_clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty messages, ignored bytes, short known strings
    push_req(8'hFF, 1'b0, 1'b1);
    push_req(8'hA5, 1'b0, 1'b0);
    push_req(8'h61, 1'b1, 1'b0);
    push_req(8'h62, 1'b1, 1'b0);
    push_req(8'h63, 1'b1, 1'b1);
    push_req(8'h00, 1'b1, 1'b1);
    push_req(8'h5A, 1'b0, 1'b0);
    push_req(8'hFF, 1'b1, 1'b1);
    push_req(8'h55, 1'b1, 1'b0);
    push_req(8'hAA, 1'b1, 1'b0);
    push_req(8'h3C, 1'b0, 1'b0);
    push_req(8'hC3, 1'b0, 1'b1);
    push_req(8'h00, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      phase = RUN_PHASES[p];
      start = queued_reqs;
      n_msg = 0;
      // one message on a padding boundary in the first phase, the rest short
      if (p == 0) begin
        bnd_len = EDGE_LEN[$urandom_range(3)];
        queue_message(bnd_len, 1'($urandom_range(1)));
        n_msg = 1;
      end
      // at least two messages so requests keep waiting during the hold-off
      while (queued_reqs - start < PHASE_REQS || n_msg < 2) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 0);
        queue_message(len, (len != 0) && ($urandom_range(1) == 1));
        n_msg++;
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (digest_fifo.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d digest words expected but never produced", $time, digest_fifo.size());
    end
    $display("run covered %0d requests, %0d messages and %0d digest words", accepted_reqs,
             msg_cnt, words_checked);
    $display("with steady, gapped, stalled and long backpressure traffic");
    if (err_cnt == 0) begin
      $display("sha1_message_hash_unit: match");
    end else begin
      $display("sha1_message_hash_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sha1_message_hash_unit: mismatch");
    $finish;
  end

endmodule

>>> sha1_message_hash_unit.f
hdl/smh_pkg.sv
hdl/smh_ctrl.sv
hdl/smh_datapath.sv
hdl/sha1_message_hash_unit.sv
hdl/smh_checker.sv
tb/tb_top.sv
